FILE: hw/rtl/itda_pkg.sv
// shared constants and types for the integer to decimal ascii unit
package itda_pkg;

  localparam int VALUE_BITS = 32;
  // decimal digits needed for any magnitude of VALUE_BITS bits (log10(2) ~ 1233/4096)
  localparam int DIGITS     = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCD_W      = DIGITS * 4;
  localparam int BIT_W      = $clog2(VALUE_BITS + 1);
  localparam int CNT_W      = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic [BCD_W-1:0]      bcd_t;

  typedef struct packed {
    logic neg;
    bcd_t bcd;
  } conv_t;

endpackage

FILE: hw/rtl/itda_if.sv
// valid/ready channel interfaces for the input value and the output characters
interface itda_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [itda_pkg::VALUE_BITS-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

FILE: hw/rtl/itda_dabble.sv
// bit-serial shift and add-3 conversion of the magnitude to packed bcd
module itda_dabble (
  input  logic            clk,
  input  logic            rst_n,
  itda_in_if.sink         in_chan,
  output logic            conv_valid,
  input  logic            conv_ready,
  output itda_pkg::conv_t conv
);
  import itda_pkg::*;

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_SHIFT = 2'd1;
  localparam logic [1:0] D_HOLD  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [BIT_W-1:0] bits_r, bits_nxt;
  mag_t             mag_r, mag_nxt;
  bcd_t             bcd_r, bcd_nxt;
  logic             neg_r, neg_nxt;
  mag_t             raw;
  bcd_t             adj;
  logic             in_fire;

  function automatic bcd_t add3(input bcd_t b);
    bcd_t r;
    r = b;
    for (int d = 0; d < DIGITS; d++) begin
      if (b[d*4 +: 4] >= 4'd5) begin
        r[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign raw           = in_chan.value;
  assign adj           = add3(bcd_r);
  assign in_chan.ready = (state_r == D_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign conv_valid    = (state_r == D_HOLD);
  assign conv.neg      = neg_r;
  assign conv.bcd      = bcd_r;

  always_comb begin
    state_nxt = state_r;
    bits_nxt  = bits_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      D_IDLE: begin
        if (in_fire) begin
          neg_nxt   = raw[VALUE_BITS-1];
          mag_nxt   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
          bcd_nxt   = '0;
          bits_nxt  = BIT_W'(VALUE_BITS);
          state_nxt = D_SHIFT;
        end
      end
      D_SHIFT: begin
        bcd_nxt  = {adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt  = {mag_r[VALUE_BITS-2:0], 1'b0};
        bits_nxt = bits_r - BIT_W'(1);
        if (bits_r == BIT_W'(1)) begin
          state_nxt = D_HOLD;
        end
      end
      D_HOLD: begin
        if (conv_ready) begin
          state_nxt = D_IDLE;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bits_r <= bits_nxt;
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
  end

endmodule

FILE: hw/rtl/itda_emit.sv
// character serialiser: sign, leading-zero skip, one digit per transaction
module itda_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            conv_valid,
  output logic            conv_ready,
  input  itda_pkg::conv_t conv,
  itda_out_if.source      out_chan
);
  import itda_pkg::*;

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_SIGN  = 2'd1;
  localparam logic [1:0] E_DIGIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  bcd_t             bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic [3:0]       top;
  logic             slot_free;
  logic             final_digit;

  assign top         = bcd_r[BCD_W-1 -: 4];
  assign slot_free   = !out_valid_r || out_chan.ready;
  assign final_digit = (cnt_r == CNT_W'(1));
  assign conv_ready  = (state_r == E_IDLE);

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ascii_char = out_char_r;
  assign out_chan.last       = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      E_IDLE: begin
        if (conv_valid) begin
          bcd_nxt     = conv.bcd;
          cnt_nxt     = CNT_W'(DIGITS);
          started_nxt = 1'b0;
          state_nxt   = conv.neg ? E_SIGN : E_DIGIT;
        end
      end
      E_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (!started_r && top == 4'd0 && !final_digit) begin
          // leading zero, drop it
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {4'd0, top};
          out_last_nxt  = final_digit;
          started_nxt   = 1'b1;
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          cnt_nxt       = cnt_r - CNT_W'(1);
          if (final_digit) begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: hw/rtl/int_to_decimal_ascii_unit.sv
// top level: signed integer to decimal ascii text converter
//
// in_chan takes one signed VALUE_BITS-bit integer per transaction (valid/ready).
// out_chan gives its decimal text one character per transaction, most
// significant first: an optional '-', then the digits with no leading zeros
// ('0' for zero); last marks the final character of each value.
// the converter loads the magnitude on the input transaction, then shifts it
// into a bcd register one bit per cycle with add-3 correction, and then
// hands the bcd word to the serialiser.
// the serialiser drops leading zeros at one digit per cycle (up to 9 at 32
// bits) and, while the receiver takes them, emits one character per cycle
// into a registered output. a negative value's '-' goes out before the
// leading-zero skip, so only a positive value's first character waits
// for it; every value walks all digit positions.
// conversion of the next value overlaps emission of the current one.
// when the receiver stalls, the output register holds its character and the
// serialiser, then the converter, stop in turn; in_chan.ready drops.
// reset (synchronous, active low) empties both stages; text in flight is lost.
module int_to_decimal_ascii_unit (
  input  logic       clk,
  input  logic       rst_n,
  itda_in_if.sink    in_chan,
  itda_out_if.source out_chan
);
  import itda_pkg::*;

  logic  conv_valid;
  logic  conv_ready;
  conv_t conv;

  itda_dabble u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv       (conv)
  );

  itda_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv       (conv),
    .out_chan   (out_chan)
  );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the integer to decimal ascii unit
`timescale 1ns / 1ps

module tb_top;
  import itda_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 50;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } text_char_t;

  typedef struct {
    value_t value;
    string  text;
  } text_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  itda_in_if  in_bus ();
  itda_out_if out_bus ();

  int_to_decimal_ascii_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  text_char_t text_q[$];
  int         mismatches = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  int         hold_reqs = 0;

  // typed text only where obvious, empty text means predicted
  text_row_t text_rows[] = '{
    '{32'sd0,            "0"},
    '{32'sd1,            "1"},
    '{-32'sd1,           "-1"},
    '{32'sd9,            "9"},
    '{32'sd10,           "10"},
    '{-32'sd10,          "-10"},
    '{32'sd99,           "99"},
    '{32'sd100,          "100"},
    '{-32'sd100,         "-100"},
    '{32'sd2147483647,   "2147483647"},
    '{32'h8000_0000,     "-2147483648"},
    '{-32'sd2147483647,  "-2147483647"},
    '{32'sd1000000000,   "1000000000"},
    '{32'sd999999999,    "999999999"},
    '{-32'sd999999999,   "-999999999"},
    '{-32'sd1000000000,  "-1000000000"},
    '{32'sd12345,        ""},
    '{-32'sd6789,        ""},
    '{32'h5555_5555,     ""},
    '{32'hAAAA_AAAA,     ""},
    '{32'sd42,           ""},
    '{32'h7FFF_FFFE,     ""},
    '{32'h8000_0001,     ""}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // decimal text of one value, most significant character first
  function automatic void queue_text_of(value_t v);
    logic             neg;
    mag_t             mag;
    logic [7:0]       chars[$];
    neg = v[VALUE_BITS-1];
    mag = neg ? mag_t'(~v + 1'b1) : mag_t'(v);
    do begin
      chars.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg)
      chars.push_front(CHAR_MINUS);
    foreach (chars[i])
      text_q.push_back('{ascii_char: chars[i], last: (i == chars.size() - 1)});
  endfunction

  function automatic value_t random_value();
    longint unsigned decade;
    value_t          v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = value_t'($urandom_range(2000)) - 1000;
      2: begin
        decade = 1;
        repeat ($urandom_range(9)) decade = decade * 10;
        v = value_t'(decade) + value_t'($urandom_range(2)) - 1;
        if ($urandom_range(1))
          v = -v;
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1))
          v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_value(value_t v, string text);
    if ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    do @(posedge clk); while (!in_bus.ready);
    if (text.len() == 0) begin
      queue_text_of(v);
    end else begin
      foreach (text[i])
        text_q.push_back('{ascii_char: text[i], last: (i == text.len() - 1)});
    end
  endtask

  // receiver side, with a long hold-off on request
  initial begin
    int holds_taken;
    int hold_left;
    holds_taken = 0;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_taken) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // output checker
  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character %h last %b", out_bus.ascii_char, out_bus.last);
      end else begin
        exp_c = text_q.pop_front();
        if (out_bus.ascii_char !== exp_c.ascii_char || out_bus.last !== exp_c.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     exp_c.ascii_char, exp_c.last, out_bus.ascii_char, out_bus.last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_bus.valid <= 1'b0;
    in_bus.value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (text_rows[i])
      send_value(text_rows[i].value, text_rows[i].text);

    // fill the unit while the receiver holds off
    hold_reqs++;
    repeat (15) send_value(random_value(), "");

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
        default: begin src_idle_pct = 6; snk_stall_pct = 6; end
      endcase
      repeat (ITEMS_PER_PHASE) send_value(random_value(), "");
    end

    in_bus.valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0 && text_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/itda_pkg.sv
hw/rtl/itda_if.sv
hw/rtl/itda_dabble.sv
hw/rtl/itda_emit.sv
hw/rtl/int_to_decimal_ascii_unit.sv
dv/tb_top.sv
